// ===== hdl/bfca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bfca_pkg
// shared types and constants for the best-fit cell allocator
// ============================================================================
package bfca_pkg;

    // default geometry
    localparam int MEM_CELLS_DEF = 1024;
    localparam int ID_BITS_DEF   = 8;

    // fixed field widths of the request and response
    localparam int PID_W = 8;
    localparam int REQ_W = 11;
    localparam int POS_W = 10;

    // request actions
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOC = 2'd0,
        STATUS_FAIL  = 2'd1,
        STATUS_FREED = 2'd2
    } bfca_status_t;

    typedef struct packed {
        logic             action;
        logic [PID_W-1:0] process_id;
        logic [REQ_W-1:0] request_size;
    } bfca_req_t;

    typedef struct packed {
        bfca_status_t     status;
        logic [POS_W-1:0] block_start;
        logic [POS_W-1:0] block_end;
    } bfca_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_FILL,
        ST_RESULT
    } bfca_state_t;

endpackage
`default_nettype wire

// ===== hdl/best_fit_cell_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// best_fit_cell_allocator
// cell allocator: best-fit allocate by owner id, release all cells of an owner
// ============================================================================
// operation: an allocate scans every cell and, when a run is found, marks
// request_size cells in a fill walk; a release scans every cell; a zero-size
// allocate skips the scan; each then waits for the response register to empty
// requests are taken one at a time, each after the last reaches the response
// register, as every non-zero request walks the one-read, one-write cell memory
// once, cell by cell, plus the fill walk on allocate
// reset: after rst_n releases, a clearing pass marks every
// cell free; no request is taken until it ends
module best_fit_cell_allocator #(
    parameter int MEM_CELLS = bfca_pkg::MEM_CELLS_DEF,
    parameter int ID_BITS   = bfca_pkg::ID_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire bfca_pkg::bfca_req_t req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output bfca_pkg::bfca_rsp_t rsp
);
    import bfca_pkg::*;

    // cell address, counter that can hold MEM_CELLS, and stored owner width
    localparam int AW    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int CW    = $clog2(MEM_CELLS + 1);
    localparam int OWN_W = (ID_BITS < PID_W) ? ID_BITS : PID_W;
    localparam int CMP_W = (CW > REQ_W) ? CW : REQ_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    bfca_state_t      state_reg, state_next;
    logic             op_reg, op_next;
    logic [OWN_W-1:0] pid_reg, pid_next;
    logic [REQ_W-1:0] want_reg, want_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;       // next cell to read / clear
    logic             rd_valid_reg, rd_valid_next;   // memory data is for rd_addr
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [CW-1:0]    run_len_reg, run_len_next;
    logic [AW-1:0]    run_start_reg, run_start_next;
    logic [CW-1:0]    best_len_reg, best_len_next;
    logic [AW-1:0]    best_start_reg, best_start_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    fill_addr_reg, fill_addr_next;
    logic [CW-1:0]    rem_reg, rem_next;             // cells still to mark
    bfca_rsp_t        res_reg, res_next;             // staged response
    logic             rsp_valid_reg, rsp_valid_next;
    bfca_rsp_t        rsp_reg, rsp_next;

    // cell memory: {used, owner}
    logic [OWN_W:0]   cell_mem [MEM_CELLS];
    logic [OWN_W:0]   rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [OWN_W:0]   mem_wdata;
    logic [AW-1:0]    mem_raddr;

    // shared run-close compare
    logic             close_run;
    logic             run_fits;
    logic             take_run;
    logic             cell_used;
    logic [OWN_W-1:0] cell_owner;
    logic             issue;

    assign cell_used  = rdata_reg[OWN_W];
    assign cell_owner = rdata_reg[OWN_W-1:0];

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // state and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rd_cnt_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pid_reg        <= pid_next;
        want_reg       <= want_next;
        rd_addr_reg    <= rd_addr_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        found_reg      <= found_next;
        fill_addr_reg  <= fill_addr_next;
        rem_reg        <= rem_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    // ------------------------------------------------------------------
    // run close: a used cell or the end of memory ends the current free run;
    // the run wins if it fits and is strictly shorter than the best so far,
    // so ties keep the earlier run
    // ------------------------------------------------------------------
    assign close_run = ((state_reg == ST_SCAN) && rd_valid_reg && (op_reg == ACT_ALLOC)
                        && cell_used) || (state_reg == ST_CLOSE);
    assign run_fits  = (CMP_W'(run_len_reg) >= CMP_W'(want_reg));
    assign take_run  = close_run && run_fits && (!found_reg || (run_len_reg < best_len_reg));

    assign issue = (state_reg == ST_SCAN) && (rd_cnt_reg < CW'(MEM_CELLS));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        want_next       = want_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        found_next      = found_reg;
        fill_addr_next  = fill_addr_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr_reg;
        mem_wdata       = '0;
        mem_raddr       = issue ? rd_cnt_reg[AW-1:0] : '0;

        // best-run update from the shared compare
        if (take_run)
        begin
            best_len_next   = run_len_reg;
            best_start_next = run_start_reg;
            found_next      = 1'b1;
        end
        if (close_run)
        begin
            run_len_next = '0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // mark every cell free, one per cycle
                mem_we    = 1'b1;
                mem_waddr = rd_cnt_reg[AW-1:0];
                mem_wdata = '0;
                if (rd_cnt_reg == CW'(MEM_CELLS - 1))
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.action;
                    pid_next     = OWN_W'(req.process_id);
                    want_next    = req.request_size;
                    rd_cnt_next  = '0;
                    run_len_next = '0;
                    found_next   = 1'b0;
                    res_next     = '{status: STATUS_FREED, block_start: '0, block_end: '0};
                    if ((req.action == ACT_ALLOC) && (req.request_size == '0))
                    begin
                        // zero-size allocate fails at once
                        res_next.status = STATUS_FAIL;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next   = rd_cnt_reg + CW'(1);
                    rd_valid_next = 1'b1;
                    rd_addr_next  = rd_cnt_reg[AW-1:0];
                end
                if (rd_valid_reg)
                begin
                    if (op_reg == ACT_RELEASE)
                    begin
                        // free a cell owned by this id, keeping its owner bits
                        if (cell_used && (cell_owner == pid_reg))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rd_addr_reg;
                            mem_wdata = {1'b0, cell_owner};
                        end
                    end
                    else if (!cell_used)
                    begin
                        if (run_len_reg == '0)
                        begin
                            run_start_next = rd_addr_reg;
                        end
                        run_len_next = run_len_reg + CW'(1);
                    end
                end
                if (!issue && !rd_valid_reg)
                begin
                    state_next = (op_reg == ACT_RELEASE) ? ST_RESULT : ST_CLOSE;
                end
            end

            ST_CLOSE:
            begin
                // end of memory closes the last run
                if (found_next)
                begin
                    fill_addr_next       = best_start_next;
                    rem_next             = CW'(want_reg);
                    res_next.status      = STATUS_ALLOC;
                    res_next.block_start = POS_W'(best_start_next);
                    state_next           = ST_FILL;
                end
                else
                begin
                    res_next.status = STATUS_FAIL;
                    state_next      = ST_RESULT;
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = {1'b1, pid_reg};
                rem_next  = rem_reg - CW'(1);
                if (rem_reg == CW'(1))
                begin
                    res_next.block_end = POS_W'(fill_addr_reg);
                    state_next         = ST_RESULT;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + AW'(1);
                end
            end

            ST_RESULT:
            begin
                // hand over to the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("cell memory written while idle");

    a_fill_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (found_reg && (rem_reg != '0)))
        else $error("fill without a chosen run or with nothing left");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN))
        else $error("cell data pending outside the scan");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("response raised outside the result step");

endmodule
`default_nettype wire
